[sv/cdd_pkg.sv]
// ----------------------------------------------------------------------------
// cdd_pkg
// Widths, constants, sequencer states and calendar tables for the
// calendar day difference block.
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int YEAR_LIMIT = 9999;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 23;

  localparam int YY_W     = YEAR_W + 1;
  localparam int MUL_K_W  = 13;
  localparam int PROD_W   = YY_W + MUL_K_W;
  localparam int Q_W      = 8;
  localparam int ACC_W    = 25;
  localparam int OFS_W    = 9;
  localparam int RECIP_SHIFT = 19;

  localparam logic [MUL_K_W-1:0] K_YEAR     = 13'd365;
  localparam logic [MUL_K_W-1:0] K_RECIP100 = 13'd5243;

  localparam logic [YY_W-1:0] YY_OFS_LATE  = 15'd400;
  localparam logic [YY_W-1:0] YY_OFS_EARLY = 15'd399;

  localparam logic signed [ACC_W-1:0] COUNT_MAX = 25'sd4194303;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_Y,
    S_CHECK,
    S_MUL_365,
    S_ADD_PROD,
    S_ADD_Q4,
    S_SUB_Q100,
    S_ADD_Q400,
    S_ADD_MON,
    S_ADD_DAY,
    S_FINISH
  } cdd_state_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the month, counting from March.
  function automatic logic [OFS_W-1:0] month_offset(input logic [MONTH_W-1:0] mm);
    logic [OFS_W-1:0] ofs;
    unique case (mm)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

[sv/cdd_req_if.sv]
// ----------------------------------------------------------------------------
// cdd_req_if
// Request channel: two dates and the include-end flag.
// ----------------------------------------------------------------------------
interface cdd_req_if;
  import cdd_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  first_year;
  logic [MONTH_W-1:0] first_month;
  logic [DAY_W-1:0]   first_day;
  logic [YEAR_W-1:0]  second_year;
  logic [MONTH_W-1:0] second_month;
  logic [DAY_W-1:0]   second_day;
  logic               include_end;

  modport source (
    output valid, first_year, first_month, first_day,
           second_year, second_month, second_day, include_end,
    input  ready
  );

  modport sink (
    input  valid, first_year, first_month, first_day,
           second_year, second_month, second_day, include_end,
    output ready
  );
endinterface

[sv/cdd_rsp_if.sv]
// ----------------------------------------------------------------------------
// cdd_rsp_if
// Response channel: signed day count and bad-date flag.
// ----------------------------------------------------------------------------
interface cdd_rsp_if;
  import cdd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COUNT_W-1:0] day_count;
  logic                      bad_date;

  modport source (
    output valid, day_count, bad_date,
    input  ready
  );

  modport sink (
    input  valid, day_count, bad_date,
    output ready
  );
endinterface

[sv/cdd_date_check.sv]
// ----------------------------------------------------------------------------
// cdd_date_check
// Validate one date: year range, month range, day within month length,
// with the leap rule taken from the registered year / 100 quotient.
// ----------------------------------------------------------------------------
module cdd_date_check (
  input  logic [cdd_pkg::YEAR_W-1:0]  year,
  input  logic [cdd_pkg::MONTH_W-1:0] month,
  input  logic [cdd_pkg::DAY_W-1:0]   day,
  input  logic [cdd_pkg::Q_W-1:0]     q100,
  output logic                        ok
);
  import cdd_pkg::*;

  logic [YEAR_W-1:0]  hundreds;
  logic [YEAR_W-1:0]  rem100;
  logic               leap;
  logic [DAY_W-1:0]   len;

  assign hundreds = (YEAR_W'(q100) << 6) + (YEAR_W'(q100) << 5) + (YEAR_W'(q100) << 2);
  assign rem100   = year - hundreds;
  assign leap     = ((year[1:0] == 2'd0) && (rem100 != '0)) ||
                    ((rem100 == '0) && (q100[1:0] == 2'd0));
  assign len      = month_len(month, leap);

  assign ok = (year >= YEAR_W'(1)) && (year <= YEAR_W'(YEAR_LIMIT)) &&
              (month >= MONTH_W'(1)) && (month <= MONTH_W'(12)) &&
              (day >= DAY_W'(1)) && (day <= len);
endmodule

[sv/calendar_day_difference.sv]
// ----------------------------------------------------------------------------
// calendar_day_difference
// Signed Gregorian day count between two dates, built on one shared
// constant multiplier and one accumulator stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink) takes a beat with two dates (year, month, day) and
//   include_end. rsp (source) returns day_count = serial(second) -
//   serial(first), magnitude bumped by include_end, and bad_date.
//   A bad year, month or day in either date gives bad_date = 1 and
//   day_count = 0.
//   Each date takes nine sequencer steps: year / 100 by reciprocal
//   multiply, validity check, 365 * year, then one accumulator add per
//   term. The response is registered as the sequencer leaves S_FINISH;
//   req.ready is high only while the sequencer is idle, so a new request
//   is taken only once the last one has left S_FINISH.
//   The response sits in its own register: the next request is accepted
//   while it waits; a new result is held back until rsp.ready drains it.
//   Reset (rst, synchronous) returns the sequencer to idle and drops any
//   pending response.
// ----------------------------------------------------------------------------
module calendar_day_difference (
  input  logic       clk,
  input  logic       rst,
  cdd_req_if.sink    req,
  cdd_rsp_if.source  rsp
);
  import cdd_pkg::*;

  cdd_state_t state, state_next;

  logic [YEAR_W-1:0]  y1, y2;
  logic [MONTH_W-1:0] m1, m2;
  logic [DAY_W-1:0]   d1, d2;
  logic               inc;
  logic               second;
  logic               bad;
  logic [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0] acc;

  logic                      out_valid;
  logic signed [COUNT_W-1:0] out_count;
  logic                      out_bad;

  logic [YEAR_W-1:0]  cur_y;
  logic [MONTH_W-1:0] cur_m;
  logic [DAY_W-1:0]   cur_d;
  logic [YY_W-1:0]    cur_yy;
  logic [MONTH_W-1:0] cur_mm;
  logic [Q_W-1:0]     q100;
  logic               date_ok;

  logic [YY_W-1:0]    mul_a;
  logic [MUL_K_W-1:0] mul_k;
  logic [PROD_W-1:0]  mul_out;

  logic [ACC_W-1:0]        addend;
  logic                    negate;
  logic signed [ACC_W-1:0] acc_next;

  logic signed [ACC_W-1:0] inc_s;
  logic signed [ACC_W-1:0] res_raw;
  logic signed [ACC_W-1:0] res_sat;

  logic accept;
  logic finish_fire;

  assign cur_y = second ? y2 : y1;
  assign cur_m = second ? m2 : m1;
  assign cur_d = second ? d2 : d1;

  assign cur_yy = {1'b0, cur_y} + ((cur_m <= MONTH_W'(2)) ? YY_OFS_EARLY : YY_OFS_LATE);
  assign cur_mm = (cur_m <= MONTH_W'(2)) ? (cur_m + MONTH_W'(9)) : (cur_m - MONTH_W'(3));
  assign q100   = prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];

  cdd_date_check u_check (
    .year  (cur_y),
    .month (cur_m),
    .day   (cur_d),
    .q100  (q100),
    .ok    (date_ok)
  );

  assign mul_a   = (state == S_MUL_Y) ? {1'b0, cur_y} : cur_yy;
  assign mul_k   = (state == S_MUL_365) ? K_YEAR : K_RECIP100;
  assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_k);

  always_comb begin
    case (state)
      S_ADD_PROD: addend = prod[ACC_W-1:0];
      S_ADD_Q4:   addend = ACC_W'(cur_yy >> 2);
      S_SUB_Q100: addend = ACC_W'(q100);
      S_ADD_Q400: addend = ACC_W'(q100 >> 2);
      S_ADD_MON:  addend = ACC_W'(month_offset(cur_mm));
      S_ADD_DAY:  addend = ACC_W'(cur_d);
      default:    addend = '0;
    endcase
  end

  assign negate   = second ? (state == S_SUB_Q100) : (state != S_SUB_Q100);
  assign acc_next = negate ? (acc - $signed(addend)) : (acc + $signed(addend));

  assign inc_s = $signed(ACC_W'(inc));

  always_comb begin
    if (acc > 0) begin
      res_raw = acc + inc_s;
    end else if (acc == 0) begin
      res_raw = inc_s;
    end else begin
      res_raw = acc - inc_s;
    end
    if (res_raw > COUNT_MAX) begin
      res_sat = COUNT_MAX;
    end else if (res_raw < -COUNT_MAX) begin
      res_sat = -COUNT_MAX;
    end else begin
      res_sat = res_raw;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (req.valid) state_next = S_MUL_Y;
      S_MUL_Y:    state_next = S_CHECK;
      S_CHECK:    state_next = S_MUL_365;
      S_MUL_365:  state_next = S_ADD_PROD;
      S_ADD_PROD: state_next = S_ADD_Q4;
      S_ADD_Q4:   state_next = S_SUB_Q100;
      S_SUB_Q100: state_next = S_ADD_Q400;
      S_ADD_Q400: state_next = S_ADD_MON;
      S_ADD_MON:  state_next = S_ADD_DAY;
      S_ADD_DAY:  state_next = second ? S_FINISH : S_MUL_Y;
      S_FINISH:   if (!out_valid || rsp.ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready   = (state == S_IDLE);
    accept      = req.valid && (state == S_IDLE);
    finish_fire = (state == S_FINISH) && (!out_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      second    <= 1'b0;
      bad       <= 1'b0;
    end else begin
      state <= state_next;
      if (finish_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        second <= 1'b0;
        bad    <= 1'b0;
      end else begin
        if (state == S_ADD_DAY) second <= 1'b1;
        if (state == S_CHECK && !date_ok) bad <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y1  <= req.first_year;
      m1  <= req.first_month;
      d1  <= req.first_day;
      y2  <= req.second_year;
      m2  <= req.second_month;
      d2  <= req.second_day;
      inc <= req.include_end;
      acc <= '0;
    end else if (state == S_ADD_PROD || state == S_ADD_Q4 || state == S_SUB_Q100 ||
                 state == S_ADD_Q400 || state == S_ADD_MON || state == S_ADD_DAY) begin
      acc <= acc_next;
    end
    if (state == S_MUL_Y || state == S_MUL_365 || state == S_ADD_PROD) begin
      prod <= mul_out;
    end
    if (finish_fire) begin
      out_bad   <= bad;
      out_count <= bad ? '0 : res_sat[COUNT_W-1:0];
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.day_count = out_count;
  assign rsp.bad_date  = out_bad;

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready
  ) else $error("request taken while sequencer busy");

  a_bad_gives_zero: assert property (
    @(posedge clk) disable iff (rst)
    (rsp.valid && rsp.bad_date) |-> (rsp.day_count == '0)
  ) else $error("bad date with nonzero count");

  a_count_in_range: assert property (
    @(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.day_count != {1'b1, {(COUNT_W-1){1'b0}}})
  ) else $error("day count outside saturation range");

  a_finish_loads_rsp: assert property (
    @(posedge clk) disable iff (rst)
    (state == S_FINISH && (!rsp.valid || rsp.ready)) |=> (rsp.valid && state == S_IDLE)
  ) else $error("finished result not presented");

endmodule

[sim/tb_calendar_day_difference.sv]
// ----------------------------------------------------------------------------
// tb_calendar_day_difference
// Self-checking bench for the Gregorian day difference block. A short
// directed list covers calendar edges, leap rules, equal dates and bad
// fields. It is followed by random date pairs, mostly valid with some
// broken. Each accepted request is scored against a day-serial predictor.
// The request side sends in random bursts. The response side stalls in
// shifting patterns, with long hold-offs that back the block up.
// ----------------------------------------------------------------------------
module tb_calendar_day_difference;
  timeunit 1ns;
  timeprecision 1ps;

  import cdd_pkg::*;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } cal_date_t;

  typedef struct {
    cal_date_t first;
    cal_date_t second;
    logic      include_end;
  } date_pair_t;

  typedef struct {
    logic signed [COUNT_W-1:0] day_count;
    logic                      bad_date;
  } day_result_t;

  localparam int SPAN_LIMIT = 4194303;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdd_req_if req ();
  cdd_rsp_if rsp ();

  calendar_day_difference dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  date_pair_t  pending_pairs[$];
  day_result_t expected_results[$];
  int          mismatch_count = 0;
  bit          req_taken = 1'b0;
  bit          hold_off = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          stall_tick = 0;
  int          stall_mode = 0;

  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(int y, int m);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return is_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic bit date_valid(cal_date_t dt);
    int y;
    int m;
    int d;
    y = int'(dt.year);
    m = int'(dt.month);
    d = int'(dt.day);
    if (y < 1 || y > YEAR_LIMIT) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return d >= 1 && d <= days_in_month(y, m);
  endfunction

  // Days since the start of year 1, counting the given day.
  function automatic int day_serial(cal_date_t dt);
    int y;
    int p;
    int n;
    y = int'(dt.year);
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int k = 1; k < int'(dt.month); k++) n += days_in_month(y, k);
    return n + int'(dt.day);
  endfunction

  function automatic day_result_t predict_day_difference(date_pair_t p);
    day_result_t r;
    int span;
    r.day_count = '0;
    r.bad_date  = 1'b1;
    if (!date_valid(p.first) || !date_valid(p.second)) return r;
    span = day_serial(p.second) - day_serial(p.first);
    if (span >= 0) span += int'(p.include_end);
    else span -= int'(p.include_end);
    if (span > SPAN_LIMIT) span = SPAN_LIMIT;
    if (span < -SPAN_LIMIT) span = -SPAN_LIMIT;
    r.day_count = span[COUNT_W-1:0];
    r.bad_date  = 1'b0;
    return r;
  endfunction

  function automatic cal_date_t make_date(int y, int m, int d);
    cal_date_t dt;
    dt.year  = y[YEAR_W-1:0];
    dt.month = m[MONTH_W-1:0];
    dt.day   = d[DAY_W-1:0];
    return dt;
  endfunction

  function automatic cal_date_t random_date();
    int edge_years[17] = '{1, 2, 3, 4, 99, 100, 101, 399, 400, 1600, 1700, 1900,
                           2000, 2100, 9996, 9998, 9999};
    int y;
    int m;
    if ($urandom_range(0, 4) == 0) y = edge_years[$urandom_range(0, 16)];
    else y = $urandom_range(1, YEAR_LIMIT);
    m = $urandom_range(1, 12);
    return make_date(y, m, $urandom_range(1, days_in_month(y, m)));
  endfunction

  function automatic cal_date_t near_date(cal_date_t base);
    int y;
    int m;
    y = int'(base.year) + $urandom_range(0, 2) - 1;
    if (y < 1) y = 1;
    if (y > YEAR_LIMIT) y = YEAR_LIMIT;
    m = $urandom_range(0, 1) ? int'(base.month) : $urandom_range(1, 12);
    return make_date(y, m, $urandom_range(1, days_in_month(y, m)));
  endfunction

  function automatic cal_date_t break_date(cal_date_t dt);
    int len;
    len = days_in_month(int'(dt.year), int'(dt.month));
    case ($urandom_range(0, 5))
      0: dt.month = '0;
      1: dt.month = MONTH_W'($urandom_range(13, 15));
      2: dt.day = '0;
      3: dt.day = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
      4: dt.year = '0;
      default: dt.year = YEAR_W'($urandom_range(YEAR_LIMIT + 1, (1 << YEAR_W) - 1));
    endcase
    return dt;
  endfunction

  task automatic add_pair(cal_date_t a, cal_date_t b, bit inc);
    date_pair_t p;
    p.first       = a;
    p.second      = b;
    p.include_end = inc;
    pending_pairs.push_back(p);
  endtask

  task automatic report_mismatch(string what);
    if (mismatch_count < 40) $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic add_random_pair();
    cal_date_t a;
    cal_date_t b;
    int pick;
    pick = $urandom_range(0, 99);
    a = random_date();
    if (pick < 55) begin
      b = random_date();
    end else if (pick < 72) begin
      b = near_date(a);
    end else if (pick < 80) begin
      b = a;
    end else if (pick < 94) begin
      b = random_date();
      if ($urandom_range(0, 1)) a = break_date(a);
      else b = break_date(b);
    end else begin
      a.year  = YEAR_W'($urandom);
      a.month = MONTH_W'($urandom);
      a.day   = DAY_W'($urandom);
      b.year  = YEAR_W'($urandom);
      b.month = MONTH_W'($urandom);
      b.day   = DAY_W'($urandom);
    end
    if ($urandom_range(0, 1)) add_pair(a, b, 1'($urandom));
    else add_pair(b, a, 1'($urandom));
  endtask

  always @(posedge clk) begin
    day_result_t want;
    date_pair_t  seen;
    req_taken = 1'b0;
    if (!rst) begin
      if (req.valid && req.ready) begin
        seen.first.year   = req.first_year;
        seen.first.month  = req.first_month;
        seen.first.day    = req.first_day;
        seen.second.year  = req.second_year;
        seen.second.month = req.second_month;
        seen.second.day   = req.second_day;
        seen.include_end  = req.include_end;
        expected_results.push_back(predict_day_difference(seen));
        req_taken = 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("response beat with nothing pending");
        end else begin
          want = expected_results.pop_front();
          if (rsp.day_count !== want.day_count)
            report_mismatch($sformatf("day_count %0d, want %0d",
                                      rsp.day_count, want.day_count));
          if (rsp.bad_date !== want.bad_date)
            report_mismatch($sformatf("bad_date %b, want %b",
                                      rsp.bad_date, want.bad_date));
        end
      end
    end
  end

  always @(negedge clk) begin
    date_pair_t nxt;
    bit show;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      show = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_pairs.size() > 0) begin
        nxt  = pending_pairs.pop_front();
        show = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      req.valid <= show;
      if (show) begin
        req.first_year   <= nxt.first.year;
        req.first_month  <= nxt.first.month;
        req.first_day    <= nxt.first.day;
        req.second_year  <= nxt.second.year;
        req.second_month <= nxt.second.month;
        req.second_day   <= nxt.second.day;
        req.include_end  <= nxt.include_end;
      end
    end
  end

  always @(negedge clk) begin
    bit take;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_tick >= 300) begin
        stall_tick = 0;
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0: take = 1'b1;
        1: take = $urandom_range(0, 3) != 0;
        2: take = (stall_tick % 7) >= 3;
        default: take = $urandom_range(0, 3) == 0;
      endcase
      rsp.ready <= take && !hold_off;
    end
  end

  // Hold the response side off for long stretches so the request side backs up.
  initial begin
    @(negedge rst);
    repeat (3) begin
      repeat ($urandom_range(2000, 6000)) @(posedge clk);
      hold_off = 1'b1;
      repeat ($urandom_range(200, 400)) @(posedge clk);
      hold_off = 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("calendar_day_difference regression: fail");
    $finish;
  end

  initial begin
    req.valid        = 1'b0;
    req.first_year   = '0;
    req.first_month  = '0;
    req.first_day    = '0;
    req.second_year  = '0;
    req.second_month = '0;
    req.second_day   = '0;
    req.include_end  = 1'b0;
    rsp.ready        = 1'b0;

    add_pair(make_date(1, 1, 1), make_date(9999, 12, 31), 1'b0);
    add_pair(make_date(1, 1, 1), make_date(9999, 12, 31), 1'b1);
    add_pair(make_date(9999, 12, 31), make_date(1, 1, 1), 1'b0);
    add_pair(make_date(9999, 12, 31), make_date(1, 1, 1), 1'b1);
    add_pair(make_date(2000, 2, 29), make_date(2000, 2, 29), 1'b0);
    add_pair(make_date(2000, 2, 29), make_date(2000, 2, 29), 1'b1);
    add_pair(make_date(9999, 12, 31), make_date(9999, 12, 31), 1'b1);
    add_pair(make_date(2024, 2, 28), make_date(2024, 3, 1), 1'b0);
    add_pair(make_date(1900, 2, 28), make_date(1900, 3, 1), 1'b1);
    add_pair(make_date(1900, 2, 29), make_date(2000, 1, 1), 1'b0);
    add_pair(make_date(2000, 2, 29), make_date(2100, 2, 28), 1'b0);
    add_pair(make_date(2023, 2, 29), make_date(2023, 3, 1), 1'b1);
    add_pair(make_date(2020, 0, 10), make_date(2021, 5, 5), 1'b0);
    add_pair(make_date(2020, 5, 10), make_date(2021, 13, 5), 1'b0);
    add_pair(make_date(2020, 15, 10), make_date(2021, 5, 5), 1'b1);
    add_pair(make_date(2020, 5, 10), make_date(2021, 5, 0), 1'b0);
    add_pair(make_date(2023, 4, 31), make_date(2023, 5, 1), 1'b0);
    add_pair(make_date(2023, 12, 31), make_date(2023, 11, 31), 1'b1);
    add_pair(make_date(0, 6, 15), make_date(10, 6, 15), 1'b0);
    add_pair(make_date(5, 6, 15), make_date(YEAR_LIMIT + 1, 6, 15), 1'b0);
    add_pair(make_date((1 << YEAR_W) - 1, 15, 31), make_date(1, 1, 1), 1'b1);
    add_pair(make_date(0, 0, 0), make_date(0, 0, 0), 1'b1);
    add_pair(make_date(1, 1, 1), make_date(1, 1, 2), 1'b0);
    add_pair(make_date(401, 1, 1), make_date(400, 12, 31), 1'b1);
    add_pair(make_date(1600, 3, 1), make_date(1600, 2, 29), 1'b0);

    repeat (1600) add_random_pair();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_pairs.size() > 0 || req.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("calendar_day_difference regression: pass");
    end else begin
      $display("calendar_day_difference regression: fail");
    end
    $finish;
  end

endmodule
